// ===== src/gem_pkg.sv =====
// Shared constants and codes for the 3x3 gradient edge magnitude block.
// No dependencies; imported by the result channel interface and the top level.

package gem_pkg;

  localparam int MAG_W = 13;
  localparam logic [MAG_W-1:0] MAG_MAX = 13'd8191;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MODE_W     = 2;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_ROBERTS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PREWITT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SOBEL   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SCHARR  = 2'd3;

  localparam logic [MODE_W-1:0]   MODE_RST   = MODE_SOBEL;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd1024;

endpackage

// ===== src/gem_pix_if.sv =====
// Pixel request channel: valid/ready handshake with gray level and flush flag.
// Standalone; width follows PIXEL_BITS.

interface gem_pix_if #(
  parameter int PIXEL_BITS = 8
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_value;
  logic                  flush;

  modport source (output valid, output pixel_value, output flush, input ready);
  modport sink   (input valid, input pixel_value, input flush, output ready);
endinterface

// ===== src/gem_res_if.sv =====
// Result request channel: valid/ready handshake with magnitude and status flags.
// Depends on gem_pkg for the magnitude width.

interface gem_res_if
  import gem_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic             out_valid;
  logic             end_of_frame;

  modport source (output valid, output magnitude, output out_valid,
                  output end_of_frame, input ready);
  modport sink   (input valid, input magnitude, input out_valid,
                  input end_of_frame, output ready);
endinterface

// ===== src/gradient_edge_magnitude_3x3.sv =====
// Top level of the 3x3 gradient edge magnitude block.
// Depends on gem_pkg, gem_pix_if and gem_res_if.
//
// Usage: gray pixels enter in raster order on pix_i; each accepted request
// yields exactly one request on res_o carrying magnitude, out_valid and
// end_of_frame. Results trail the pixels by one image row plus one pixel,
// so after a frame's last pixel the source sends image_width+1 flush
// requests to drain it. Border rows and columns give magnitude 0.
// Configuration (filter_mode, image_width, image_height) is to be written by
// the user through cfg_we_i/cfg_idx_i/cfg_data_i only while the block is
// idle; the block does not enforce this. Writing any of these three
// registers restarts the frame counters.
// Timing: one request at a time. After acceptance the line stores are read,
// the window shifts, the gradients and their squares are registered, and an
// iterative square root of PIXEL_BITS+5 iterations produces one result bit
// per cycle. The next pixel is taken once the result is in the output
// register, so a new pixel is accepted while the receiver stalls; a second
// result then waits until it is taken.
// Reset: configuration returns to Sobel, 1024x1024; counters and window
// clear; line store contents are left as they are.

module gradient_edge_magnitude_3x3
  import gem_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  gem_pix_if.sink               pix_i,
  gem_res_if.source             res_o
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WE     = CW + 1;
  localparam int FW     = CW + 2;
  localparam int ROW_W  = HEIGHT_W + 1;
  localparam int GW     = PIXEL_BITS + 6;
  localparam int AW     = PIXEL_BITS + 4;
  localparam int ROOT_W = PIXEL_BITS + 5;
  localparam int SW     = 2 * ROOT_W;
  localparam int IW     = $clog2(ROOT_W + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_GRAD = 3'd2;
  localparam logic [2:0] ST_SQR  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_ROOT = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  // configuration
  logic [MODE_W-1:0]   mode_q;
  logic [WIDTH_W-1:0]  wid_q;
  logic [HEIGHT_W-1:0] hgt_q;
  logic [WE-1:0]       wid_eff;
  logic [HEIGHT_W-1:0] hgt_eff;

  // frame position
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [FW-1:0]    fill_q, fill_d;

  // per-item control
  logic [2:0]            state_q, state_d;
  logic [PIXEL_BITS-1:0] pix_q;
  logic [CW-1:0]         wcol_q;
  logic                  inner_q, vld_q, eof_q;

  // line stores
  logic [PIXEL_BITS-1:0] up_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] lo_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] up_rd_q, lo_rd_q;

  logic [PIXEL_BITS-1:0] win_q [9];

  logic [AW-1:0]     gxa_q, gya_q;
  logic [2*AW-1:0]   sqx_q, sqy_q;
  logic [SW-1:0]     val_q;
  logic [ROOT_W+1:0] rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [IW-1:0]     it_q;

  logic             res_valid_q;
  logic [MAG_W-1:0] res_mag_q;
  logic             res_ov_q, res_eof_q;

  logic accept, out_load;

  assign accept   = pix_i.valid && pix_i.ready;
  assign pix_i.ready = (state_q == ST_IDLE);
  assign out_load = (state_q == ST_DONE) && (!res_valid_q || res_o.ready);

  always_comb begin
    if (wid_q == '0) begin
      wid_eff = WE'(1);
    end else if (32'(wid_q) > MAX_WIDTH) begin
      wid_eff = WE'(MAX_WIDTH);
    end else begin
      wid_eff = WE'(wid_q);
    end
    hgt_eff = (hgt_q == '0) ? HEIGHT_W'(1) : hgt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RST;
      wid_q  <= WIDTH_RST;
      hgt_q  <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FILTER_MODE:  mode_q <= cfg_data_i[MODE_W-1:0];
        CFG_IMAGE_WIDTH:  wid_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: hgt_q  <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // position of the result this request produces
  logic [FW-1:0]    wid_p1;
  logic             vld_n, eof_n, inner_n, col_wrap;
  logic [ROW_W-1:0] orow;
  logic [WE-1:0]    ocol, col_nx;
  logic             cfg_hit;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == CFG_FILTER_MODE || cfg_idx_i == CFG_IMAGE_WIDTH
                                || cfg_idx_i == CFG_IMAGE_HEIGHT);

  always_comb begin
    wid_p1   = FW'(wid_eff) + FW'(1);
    vld_n    = (fill_q >= wid_p1);
    if (col_q != '0) begin
      orow = row_q - ROW_W'(1);
      ocol = WE'(col_q) - WE'(1);
    end else begin
      orow = row_q - ROW_W'(2);
      ocol = wid_eff - WE'(1);
    end
    eof_n   = vld_n && (col_q == '0) && (row_q == ROW_W'(hgt_eff) + ROW_W'(1));
    inner_n = vld_n && (orow != '0) && (orow < ROW_W'(hgt_eff) - ROW_W'(1))
              && (ocol != '0) && (ocol < wid_eff - WE'(1));
    col_nx   = WE'(col_q) + WE'(1);
    col_wrap = (col_nx >= wid_eff);

    col_d  = col_q;
    row_d  = row_q;
    fill_d = fill_q;
    if (cfg_hit) begin
      col_d  = '0;
      row_d  = '0;
      fill_d = '0;
    end else if (accept) begin
      if (eof_n) begin
        col_d  = '0;
        row_d  = '0;
        fill_d = '0;
      end else begin
        col_d  = col_wrap ? '0 : col_nx[CW-1:0];
        row_d  = col_wrap ? row_q + ROW_W'(1) : row_q;
        fill_d = vld_n ? fill_q : fill_q + FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      fill_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q   <= pix_i.flush ? '0 : PIXEL_BITS'(pix_i.pixel_value);
      wcol_q  <= col_q;
      inner_q <= inner_n;
      vld_q   <= vld_n;
      eof_q   <= eof_n;
    end
  end

  // line stores: read at acceptance, written back in the next cycle (ST_READ)
  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_rd_q <= up_mem[col_q];
    end
    if (state_q == ST_READ) begin
      up_mem[wcol_q] <= lo_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lo_rd_q <= lo_mem[col_q];
    end
    if (state_q == ST_READ) begin
      lo_mem[wcol_q] <= pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (state_q == ST_READ) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= up_rd_q;
      win_q[5] <= lo_rd_q;
      win_q[8] <= pix_q;
    end
  end

  // kernel sums
  logic signed [GW-1:0] e [9];
  logic signed [GW-1:0] dx0, dx1, dx2, dy0, dy1, dy2, sx, sy, gx, gy;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      e[k] = $signed({{(GW-PIXEL_BITS){1'b0}}, win_q[k]});
    end
    dx0 = e[0] - e[2];
    dx1 = e[3] - e[5];
    dx2 = e[6] - e[8];
    dy0 = e[0] - e[6];
    dy1 = e[1] - e[7];
    dy2 = e[2] - e[8];
    sx  = dx0 + dx2;
    sy  = dy0 + dy2;
    case (mode_q)
      MODE_ROBERTS: begin
        gx = e[4] - e[8];
        gy = e[5] - e[7];
      end
      MODE_PREWITT: begin
        gx = sx + dx1;
        gy = sy + dy1;
      end
      MODE_SOBEL: begin
        gx = sx + (dx1 <<< 1);
        gy = sy + (dy1 <<< 1);
      end
      default: begin
        gx = (sx <<< 1) + sx + (dx1 <<< 3) + (dx1 <<< 1);
        gy = (sy <<< 1) + sy + (dy1 <<< 3) + (dy1 <<< 1);
      end
    endcase
  end

  logic signed [GW-1:0] gx_abs, gy_abs;
  assign gx_abs = gx[GW-1] ? -gx : gx;
  assign gy_abs = gy[GW-1] ? -gy : gy;

  // root step: bring in two bits, try subtracting 4r+1
  logic [ROOT_W+1:0] rem_sh, trial;
  logic              fits;

  always_comb begin
    rem_sh = {rem_q[ROOT_W-1:0], val_q[SW-1:SW-2]};
    trial  = {root_q, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_GRAD: begin
        gxa_q <= gx_abs[AW-1:0];
        gya_q <= gy_abs[AW-1:0];
      end
      ST_SQR: begin
        sqx_q <= gxa_q * gxa_q;
        sqy_q <= gya_q * gya_q;
      end
      ST_SUM: begin
        val_q  <= SW'(sqx_q) + SW'(sqy_q);
        rem_q  <= '0;
        root_q <= '0;
        it_q   <= '0;
      end
      ST_ROOT: begin
        val_q  <= val_q << 2;
        rem_q  <= fits ? rem_sh - trial : rem_sh;
        root_q <= {root_q[ROOT_W-2:0], fits};
        it_q   <= it_q + IW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_READ;
      ST_READ: state_d = ST_GRAD;
      ST_GRAD: state_d = ST_SQR;
      ST_SQR:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_ROOT;
      ST_ROOT: if (it_q == IW'(ROOT_W - 1)) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  logic [MAG_W-1:0] mag_sat;
  assign mag_sat = (32'(root_q) > 32'(MAG_MAX)) ? MAG_MAX : MAG_W'(root_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_mag_q <= inner_q ? mag_sat : '0;
      res_ov_q  <= vld_q;
      res_eof_q <= eof_q;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.magnitude    = res_mag_q;
  assign res_o.out_valid    = res_ov_q;
  assign res_o.end_of_frame = res_eof_q;

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_READ)
    else $error("accepted request did not start a store read");

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WE'(col_q) < wid_eff)
    else $error("column count outside image width");

  a_eof_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_eof_q |-> res_ov_q)
    else $error("end of frame on a result without position");

  a_root_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROOT |-> 32'(it_q) < ROOT_W)
    else $error("root iteration count overrun");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> res_valid_q && state_q == ST_IDLE)
    else $error("finished result not presented");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for gradient_edge_magnitude_3x3: streams raster pixels, predicts every
// result in a local copy of the line stores, window and frame counters, and checks each one.
// Depends on gem_pkg, gem_pix_if, gem_res_if and the block itself.

module tb_top;
  import gem_pkg::*;

  localparam int MAX_WIDTH   = 1024;
  localparam int PIXEL_BITS  = 8;
  localparam int PIPE_CYCLES = PIXEL_BITS + 24;
  localparam int DRAIN_LIMIT = 20000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             out_valid;
    logic             end_of_frame;
  } edge_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  gem_pix_if #(.PIXEL_BITS(PIXEL_BITS)) pix ();
  gem_res_if res ();

  gradient_edge_magnitude_3x3 #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix_i     (pix),
    .res_o     (res)
  );

  // Local copy of the block's state
  logic [PIXEL_BITS-1:0] upper_line [MAX_WIDTH] = '{default: '0};
  logic [PIXEL_BITS-1:0] lower_line [MAX_WIDTH] = '{default: '0};
  logic [PIXEL_BITS-1:0] win [9] = '{default: '0};
  logic [MODE_W-1:0]     kernel_mode = MODE_RST;
  logic [WIDTH_W-1:0]    width_reg = WIDTH_RST;
  logic [HEIGHT_W-1:0]   height_reg = HEIGHT_RST;
  int                    col_pos = 0;
  int                    row_pos = 0;
  int                    items_in_frame = 0;

  edge_result_t magnitudes_due [$];

  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int hold_len = 0;
  int hold_seq = 0;
  int pixels_sent = 0;
  int results_checked = 0;
  int frames_done = 0;
  int edges_seen = 0;
  int mismatch_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic int active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  function automatic logic [PIXEL_BITS-1:0] pick_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIXEL_BITS'($urandom_range(255));
    endcase
  endfunction

  // Shift one pixel through the stores and window, then queue the result it yields.
  task automatic compute_edge_magnitude(input logic [PIXEL_BITS-1:0] value, input logic fl);
    edge_result_t          r;
    logic [PIXEL_BITS-1:0] px, up, lo;
    int w, h, orow, ocol, gx, gy, sq, root, trial, b, i;
    int t [9];
    w = active_width();
    h = active_height();
    px = fl ? '0 : value;
    up = upper_line[col_pos];
    lo = lower_line[col_pos];
    upper_line[col_pos] = lo;
    lower_line[col_pos] = px;
    for (i = 0; i < 3; i++) begin
      win[i*3]     = win[i*3 + 1];
      win[i*3 + 1] = win[i*3 + 2];
    end
    win[2] = up;
    win[5] = lo;
    win[8] = px;

    r.out_valid = (items_in_frame >= w + 1);
    if (col_pos >= 1) begin
      orow = row_pos - 1;
      ocol = col_pos - 1;
    end else begin
      orow = row_pos - 2;
      ocol = w - 1;
    end
    r.end_of_frame = r.out_valid && col_pos == 0 && row_pos == h + 1;
    r.magnitude = '0;

    if (r.out_valid && orow >= 1 && orow + 1 < h && ocol >= 1 && ocol + 1 < w) begin
      for (i = 0; i < 9; i++) t[i] = int'(win[i]);
      case (kernel_mode)
        MODE_ROBERTS: begin
          gx = t[4] - t[8];
          gy = t[5] - t[7];
        end
        MODE_PREWITT: begin
          gx = (t[0] + t[3] + t[6]) - (t[2] + t[5] + t[8]);
          gy = (t[0] + t[1] + t[2]) - (t[6] + t[7] + t[8]);
        end
        MODE_SOBEL: begin
          gx = (t[0] + 2*t[3] + t[6]) - (t[2] + 2*t[5] + t[8]);
          gy = (t[0] + 2*t[1] + t[2]) - (t[6] + 2*t[7] + t[8]);
        end
        default: begin
          gx = (3*t[0] + 10*t[3] + 3*t[6]) - (3*t[2] + 10*t[5] + 3*t[8]);
          gy = (3*t[0] + 10*t[1] + 3*t[2]) - (3*t[6] + 10*t[7] + 3*t[8]);
        end
      endcase
      sq = gx*gx + gy*gy;
      // Bitwise floor root; 13 result bits also give the saturation at MAG_MAX
      root = 0;
      for (b = MAG_W - 1; b >= 0; b--) begin
        trial = root | (1 << b);
        if (trial * trial <= sq) root = trial;
      end
      r.magnitude = MAG_W'(root);
    end

    if (r.end_of_frame) begin
      col_pos = 0;
      row_pos = 0;
      items_in_frame = 0;
    end else begin
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      items_in_frame++;
    end
    magnitudes_due.push_back(r);
  endtask

  // Offer one pixel request; valid stays high afterwards unless the next call idles.
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] value, input logic fl);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid       <= 1'b1;
    pix.pixel_value <= value;
    pix.flush       <= fl;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    compute_edge_magnitude(value, fl);
    pixels_sent++;
  endtask

  task automatic drain_frame(input int w);
    int i;
    for (i = 0; i <= w; i++) send_pixel(pick_pixel(), 1'b1);
  endtask

  task automatic wait_results_drained();
    int spins;
    pix.valid <= 1'b0;
    spins = 0;
    while (magnitudes_due.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk_i);
      spins++;
    end
    if (magnitudes_due.size() != 0) begin
      log_mismatch($sformatf("%0d results never arrived", magnitudes_due.size()));
      magnitudes_due.delete();
    end
    repeat (PIPE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    logic known;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    known = 1'b1;
    case (idx)
      CFG_FILTER_MODE:  kernel_mode = data[MODE_W-1:0];
      CFG_IMAGE_WIDTH:  width_reg = data[WIDTH_W-1:0];
      CFG_IMAGE_HEIGHT: height_reg = data[HEIGHT_W-1:0];
      default:          known = 1'b0;
    endcase
    if (known) begin
      col_pos = 0;
      row_pos = 0;
      items_in_frame = 0;
    end
  endtask

  task automatic configure_frame(input logic [MODE_W-1:0] mode, input int w, input int h);
    wait_results_drained();
    write_reg(CFG_FILTER_MODE, {11'($urandom), mode});
    write_reg(CFG_IMAGE_WIDTH, {2'($urandom_range(3)), 11'(w)});
    write_reg(CFG_IMAGE_HEIGHT, 13'(h));
  endtask

  // Reset geometry (Sobel, full 1024-pixel rows): the start of the first row stays in fill.
  task automatic test_reset_config();
    int i;
    for (i = 0; i < MAX_WIDTH / 16; i++) send_pixel(pick_pixel(), 1'b0);
  endtask

  // Every kernel pair on a 3x3 frame with full-scale contrast; last drain item is a pixel.
  task automatic test_kernel_extremes();
    int m, r, c;
    for (m = 0; m < 4; m++) begin
      configure_frame(MODE_W'(m), 3, 3);
      for (r = 0; r < 3; r++)
        for (c = 0; c < 3; c++)
          send_pixel((r == 0 || c == 0) ? '1 : '0, 1'b0);
      for (r = 0; r < 3; r++) send_pixel('1, 1'b1);
      send_pixel('1, 1'b0);
    end
  endtask

  // Degenerate geometries, zero width and height among them.
  task automatic test_tiny_frames();
    int tw [6] = '{0, 1, 2, 5, 1, 3};
    int th [6] = '{0, 1, 5, 2, 4, 1};
    int k, i;
    for (k = 0; k < 6; k++) begin
      configure_frame(MODE_W'($urandom_range(3)), tw[k], th[k]);
      for (i = 0; i < active_width() * active_height(); i++) send_pixel(pick_pixel(), 1'b0);
      drain_frame(active_width());
    end
  endtask

  // A write to the spare index must not restart the frame; a known register must.
  task automatic test_spare_index_and_restart();
    int i;
    configure_frame(MODE_PREWITT, 5, 4);
    for (i = 0; i < 9; i++) send_pixel(pick_pixel(), i == 6);
    wait_results_drained();
    write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    for (i = 9; i < 20; i++) send_pixel(pick_pixel(), 1'b0);
    drain_frame(5);
    for (i = 0; i < 7; i++) send_pixel(pick_pixel(), 1'b0);
    wait_results_drained();
    write_reg(CFG_IMAGE_WIDTH, 13'd4);
    for (i = 0; i < 16; i++) send_pixel(pick_pixel(), 1'b0);
    drain_frame(4);
  endtask

  // Hold the result side long enough to stall the input, then pause the sender mid-frame.
  task automatic test_backpressure();
    int r, c;
    configure_frame(MODE_SOBEL, 6, 5);
    hold_len <= 300;
    hold_seq <= hold_seq + 1;
    for (r = 0; r < 5; r++) begin
      for (c = 0; c < 6; c++) send_pixel(pick_pixel(), 1'b0);
      if (r == 2) wait_results_drained();
    end
    drain_frame(6);
  endtask

  // Width above the maximum clamps: out_valid must rise after 1025 items.
  task automatic test_width_clamp();
    int i;
    configure_frame(MODE_SCHARR, 1024, 3);
    write_reg(CFG_IMAGE_WIDTH, 13'h07FF);
    write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
    write_reg(CFG_IMAGE_HEIGHT, 13'd4096);
    for (i = 0; i < MAX_WIDTH + 4; i++) send_pixel(pick_pixel(), 1'b0);
  endtask

  // Mostly complete frames with random content; some aborted, short-drained or flushed inside.
  task automatic test_random_frames(input int count);
    int goal, w, h, n_pix, n_drain, shape, i;
    logic first;
    goal = pixels_sent + count;
    first = 1'b1;
    while (pixels_sent < goal) begin
      if (first || $urandom_range(3) != 0) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        if ($urandom_range(29) == 0) w = $urandom_range(20, 40);
        h = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        configure_frame(MODE_W'($urandom_range(3)), w, h);
        first = 1'b0;
      end
      shape = $urandom_range(99);
      n_pix = active_width() * active_height();
      if (shape < 8) n_pix = $urandom_range(1, n_pix);
      for (i = 0; i < n_pix; i++) send_pixel(pick_pixel(), $urandom_range(99) < 4);
      if (shape < 8) n_drain = 0;
      else if (shape < 16) n_drain = $urandom_range(0, active_width());
      else n_drain = active_width() + 1;
      for (i = 0; i < n_drain; i++) send_pixel(pick_pixel(), $urandom_range(99) >= 20);
    end
  endtask

  initial begin : result_receiver
    int stall_left;
    int seen_seq;
    stall_left = 0;
    seen_seq = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (seen_seq != hold_seq) begin
        seen_seq = hold_seq;
        stall_left = hold_len;
      end
      if (stall_left > 0) begin
        res.ready <= 1'b0;
        stall_left--;
      end else begin
        res.ready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    edge_result_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (magnitudes_due.size() == 0) begin
        log_mismatch($sformatf("unrequested result: mag %0d valid %0b eof %0b",
                               res.magnitude, res.out_valid, res.end_of_frame));
      end else begin
        want = magnitudes_due.pop_front();
        if (res.magnitude !== want.magnitude || res.out_valid !== want.out_valid ||
            res.end_of_frame !== want.end_of_frame)
          log_mismatch($sformatf(
            "result %0d: expected mag %0d valid %0b eof %0b, got mag %0d valid %0b eof %0b",
            results_checked, want.magnitude, want.out_valid, want.end_of_frame,
            res.magnitude, res.out_valid, res.end_of_frame));
        if (want.end_of_frame) frames_done++;
        if (want.magnitude != 0) edges_seen++;
      end
      results_checked++;
    end
  end

  initial begin
    #10_000_000;
    $display("run stopped: time limit reached with %0d results pending", magnitudes_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_data_i      <= '0;
    pix.valid       <= 1'b0;
    pix.pixel_value <= '0;
    pix.flush       <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 7;
    take_idle_pct = 85;
    test_reset_config();
    test_kernel_extremes();
    test_tiny_frames();
    test_spare_index_and_restart();
    test_random_frames(170);

    send_idle_pct = 85;
    take_idle_pct = 7;
    test_random_frames(170);

    send_idle_pct = 0;
    take_idle_pct = 0;
    test_backpressure();
    test_width_clamp();
    test_random_frames(170);

    wait_results_drained();
    $display("covered %0d pixel requests, %0d results checked, %0d complete frames",
             pixels_sent, results_checked, frames_done);
    $display("all four kernel pairs, widths 1 to 1024 with clamping, %0d nonzero edges, stalls",
             edges_seen);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
